@@ rtl/cxfb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cxfb_pkg
// Shared constants, types and the CRC-16/X-25 byte update for the frame
// builder.
// ----------------------------------------------------------------------------
package cxfb_pkg;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'h8408;
   localparam logic [7:0]  HEADER_BYTE  = 8'h01;
   localparam logic [7:0]  TRAILER_BYTE = 8'h1E;

   // reflected crc update, one byte, lsb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic [7:0]  b;
      c = crc;
      b = data;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
         b = b >> 1;
      end
      return c;
   endfunction

   // crc state once the header byte has been folded in
   localparam logic [15:0] CRC_AFTER_HEADER = crc_feed(CRC_INIT, HEADER_BYTE);

   // one accepted request with everything the output side needs
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        header;
      logic [15:0] fcs;
   } item_type;

endpackage
`default_nettype wire

@@ rtl/cxfb_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cxfb_req_if
// Request channel: payload byte and last-of-frame mark with valid/ready.
// ----------------------------------------------------------------------------
interface cxfb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/cxfb_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cxfb_rsp_if
// Result channel: framed byte and end-of-frame mark with valid/ready.
// ----------------------------------------------------------------------------
interface cxfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_frame;

   modport source (output valid, output out_byte, output end_of_frame, input ready);
   modport sink   (input valid, input out_byte, input end_of_frame, output ready);
endinterface
`default_nettype wire

@@ rtl/crc16_x25_frame_builder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_x25_frame_builder_unit
// Frames a payload byte stream: header 0x01, payload, trailer 0x1e and the
// CRC-16/X-25 check (low byte first) over header and payload.
// ----------------------------------------------------------------------------
// usage
//   req_chan carries payload bytes with last_byte set on the final byte of a
//   frame; rsp_chan delivers the framed bytes, end_of_frame set on the high
//   check byte. both channels move a request when valid and ready are high.
//   a request yields 1 byte mid-frame, 2 when it opens a frame, 4 when it
//   closes one and 5 for a one-byte frame. the output side sends one byte per
//   cycle while rsp_chan is ready, so a request holds the item slot until its
//   last byte moves to the output register; mid-frame requests stream at one
//   per cycle while rsp_chan is ready.
//   the first byte of a request goes through the item slot, then the output
//   register, before it shows on rsp_chan. when rsp_chan stalls the output
//   register holds its byte, the slot holds its item, and req_chan.ready drops once the slot cannot drain.
//   reset (synchronous, active high) empties slot and output register and
//   puts the frame tracker in the waiting-for-first-byte state with the crc
//   at 0xffff.
// ----------------------------------------------------------------------------
module crc16_x25_frame_builder_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   cxfb_req_if.sink   req_chan,
   cxfb_rsp_if.source rsp_chan
);

   cxfb_pkg::item_type item;
   logic               req_ready;
   logic               accept;

   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid & req_ready;

   cxfb_frame_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .item      (item)
   );

   cxfb_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .item      (item),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

@@ rtl/cxfb_frame_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cxfb_frame_tracker
// Keeps the running frame CRC and the in-frame flag, and turns each accepted
// request into an item carrying the header flag and the final check value.
// ----------------------------------------------------------------------------
module cxfb_frame_tracker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              last_byte,
   output cxfb_pkg::item_type     item
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        inside_ff;
   logic        inside_in;
   logic [15:0] crc_base;
   logic [15:0] crc_new;

   // a new frame starts from the state after the header byte
   assign crc_base = inside_ff ? crc_ff : cxfb_pkg::CRC_AFTER_HEADER;
   assign crc_new  = cxfb_pkg::crc_feed(crc_base, data_byte);

   always_comb begin
      item.data_byte = data_byte;
      item.last_byte = last_byte;
      item.header    = ~inside_ff;
      item.fcs       = ~crc_new;
   end

   always_comb begin
      crc_in    = crc_ff;
      inside_in = inside_ff;
      if (accept) begin
         if (last_byte) begin
            crc_in    = cxfb_pkg::CRC_INIT;
            inside_in = 1'b0;
         end else begin
            crc_in    = crc_new;
            inside_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= cxfb_pkg::CRC_INIT;
         inside_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         inside_ff <= inside_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_close_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> !inside_ff && crc_ff == cxfb_pkg::CRC_INIT)
      else $error("frame close did not restart crc state");
`endif

endmodule
`default_nettype wire

@@ rtl/cxfb_emitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cxfb_emitter
// Holds one item and steps through its bytes (header, payload, trailer, two
// check bytes) into the output register, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module cxfb_emitter (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire cxfb_pkg::item_type  item,
   cxfb_rsp_if.source               rsp_chan
);

   typedef enum logic [4:0] {
      PH_HEADER  = 5'b00001,
      PH_DATA    = 5'b00010,
      PH_TRAILER = 5'b00100,
      PH_FCS_LO  = 5'b01000,
      PH_FCS_HI  = 5'b10000
   } phase_type;

   cxfb_pkg::item_type slot_ff;
   cxfb_pkg::item_type slot_in;
   logic               slot_valid_ff;
   logic               slot_valid_in;
   phase_type          phase_ff;
   phase_type          phase_in;
   phase_type          phase_step;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [7:0]         out_byte_ff;
   logic [7:0]         out_byte_in;
   logic               out_eof_ff;
   logic               out_eof_in;

   logic               out_free;
   logic               advance;
   logic               last_step;
   logic               slot_done;
   logic               accept;
   logic [7:0]         sel_byte;
   logic               sel_eof;

   assign out_free  = ~out_valid_ff | rsp_chan.ready;
   assign advance   = slot_valid_ff & out_free;
   assign slot_done = advance & last_step;
   assign req_ready = ~slot_valid_ff | slot_done;
   assign accept    = req_valid & req_ready;

   always_comb begin
      sel_byte   = slot_ff.data_byte;
      sel_eof    = 1'b0;
      last_step  = 1'b0;
      phase_step = PH_DATA;
      unique case (phase_ff)
         PH_HEADER: begin
            sel_byte   = cxfb_pkg::HEADER_BYTE;
            phase_step = PH_DATA;
         end
         PH_DATA: begin
            sel_byte   = slot_ff.data_byte;
            last_step  = ~slot_ff.last_byte;
            phase_step = PH_TRAILER;
         end
         PH_TRAILER: begin
            sel_byte   = cxfb_pkg::TRAILER_BYTE;
            phase_step = PH_FCS_LO;
         end
         PH_FCS_LO: begin
            sel_byte   = slot_ff.fcs[7:0];
            phase_step = PH_FCS_HI;
         end
         PH_FCS_HI: begin
            sel_byte   = slot_ff.fcs[15:8];
            sel_eof    = 1'b1;
            last_step  = 1'b1;
            phase_step = PH_DATA;
         end
         default: begin
            sel_byte   = slot_ff.data_byte;
            last_step  = 1'b1;
            phase_step = PH_DATA;
         end
      endcase
   end

   always_comb begin
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      phase_in      = phase_ff;
      if (accept) begin
         slot_in       = item;
         slot_valid_in = 1'b1;
         phase_in      = item.header ? PH_HEADER : PH_DATA;
      end else if (slot_done) begin
         slot_valid_in = 1'b0;
      end else if (advance) begin
         phase_in = phase_step;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_eof_in   = out_eof_ff;
      if (out_free) begin
         out_valid_in = slot_valid_ff;
         out_byte_in  = sel_byte;
         out_eof_in   = sel_eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         phase_ff      <= PH_DATA;
         out_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         phase_ff      <= phase_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      out_byte_ff <= out_byte_in;
      out_eof_ff  <= out_eof_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.end_of_frame = out_eof_ff;

`ifndef NO_ASSERTIONS
   a_overwrite_only_when_done: assert property (@(posedge clock) disable iff (reset)
      accept && slot_valid_ff |-> slot_done)
      else $error("item slot overwritten before its last byte went out");

   a_no_trailer_mid_frame: assert property (@(posedge clock) disable iff (reset)
      slot_valid_ff && !slot_ff.last_byte |->
         !(phase_ff == PH_TRAILER || phase_ff == PH_FCS_LO || phase_ff == PH_FCS_HI))
      else $error("trailer phase reached on a byte that does not close the frame");

   a_header_only_on_open: assert property (@(posedge clock) disable iff (reset)
      slot_valid_ff && phase_ff == PH_HEADER |-> slot_ff.header)
      else $error("header emitted inside an open frame");

   a_eof_after_fcs_lo: assert property (@(posedge clock) disable iff (reset)
      out_free && slot_valid_ff && phase_ff == PH_FCS_HI |-> $past(phase_ff) == PH_FCS_LO
         || $past(phase_ff) == PH_FCS_HI)
      else $error("high check byte not preceded by low check byte");
`endif

endmodule
`default_nettype wire
